FILE: rtl/nfaec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfaec_pkg
// Shared types and constants for the NFA epsilon-closure matcher.
// ----------------------------------------------------------------------------
package nfaec_pkg;

  localparam int NUM_STATES  = 16;
  localparam int SYMBOL_BITS = 8;
  localparam int STATE_W     = $clog2(NUM_STATES);
  localparam int IDX_W       = STATE_W + 1;
  localparam int ADDR_W      = STATE_W + SYMBOL_BITS;
  localparam int MEM_DEPTH   = NUM_STATES << SYMBOL_BITS;
  localparam int OUT_SET_W   = 16;

  typedef logic [NUM_STATES-1:0] mask_t;

  typedef enum logic [2:0] {
    MODE_ADD_SYM  = 3'd0,
    MODE_ADD_EPS  = 3'd1,
    MODE_SET_STOP = 3'd2,
    MODE_BEGIN    = 3'd3,
    MODE_CONSUME  = 3'd4,
    MODE_CLEAR    = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_WR,
    ST_SCAN,
    ST_CLOSE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] from_state;
    logic [3:0] to_state;
    logic [7:0] symbol;
    logic       stop_flag;
  } nfaec_in_t;

  typedef struct packed {
    logic [15:0] active_set;
    logic        accepting;
    logic        dead;
  } nfaec_out_t;

endpackage

FILE: rtl/nfaec_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfaec_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nfaec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/nfa_epsilon_closure_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_epsilon_closure_matcher_core
// Steps an NFA held in on-chip stores: symbol-edge RAM, epsilon-edge masks,
// accept mask and the active-state set, one transaction at a time.
// ----------------------------------------------------------------------------
// Sequencing: edits and unused modes go straight to DONE; a symbol-edge add reads
//   then writes its RAM row; begin runs the closure; consume reads a row per state,
//   then runs the closure, one closure pass per cycle.
// Reset: synchronous active-low; reset and clear-all run a RAM clearing sweep over all
//   4096 entries with in_ready low. cfg writes are taken at any time.
module nfa_epsilon_closure_matcher_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  nfaec_pkg::nfaec_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output nfaec_pkg::nfaec_out_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_data
);
  import nfaec_pkg::*;

  state_t              state_r, state_nxt;
  nfaec_in_t           item_r, item_nxt;
  mask_t               set_r, set_nxt;
  mask_t               active_r, active_nxt;
  mask_t               accept_r, accept_nxt;
  mask_t               eps_r [NUM_STATES];
  mask_t               eps_nxt [NUM_STATES];
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                rd_sel_r, rd_sel_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic                clr_reply_r, clr_reply_nxt;
  logic                out_valid_r, out_valid_nxt;
  nfaec_out_t          out_data_r, out_data_nxt;
  logic [3:0]          start_r;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  mask_t               ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  mask_t               ram_rdata;

  logic                in_fire;
  logic                in_edge_ok;
  logic                from_ok;
  logic [ADDR_W-1:0]   edge_addr;
  mask_t               eps_union;
  mask_t               grown;
  logic                close_done;
  logic                scan_end;
  mask_t               scan_acc;
  logic                clr_last;
  logic                out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_edge_ok   = (int'(in_data.from_state) < NUM_STATES) &&
                        (int'(in_data.to_state) < NUM_STATES);
  assign from_ok      = int'(in_data.from_state) < NUM_STATES;
  assign edge_addr    = {item_r.from_state[STATE_W-1:0], item_r.symbol[SYMBOL_BITS-1:0]};

  // Closure unit: one epsilon pass over the current set per cycle
  always_comb begin
    eps_union = '0;
    for (int i = 0; i < NUM_STATES; i++) begin
      if (set_r[i]) begin
        eps_union = eps_union | eps_r[i];
      end
    end
  end

  assign grown      = set_r | eps_union;
  assign close_done = (grown == set_r);
  assign scan_end   = (idx_r == IDX_W'(NUM_STATES));
  assign scan_acc   = set_r | ((rd_vld_r && rd_sel_r) ? ram_rdata : '0);
  assign clr_last   = (clr_r == ADDR_W'(MEM_DEPTH - 1));
  assign out_free   = !out_valid_r || out_ready;

  nfaec_ram #(
    .WIDTH (NUM_STATES),
    .DEPTH (MEM_DEPTH)
  ) u_sym_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.mode)
            MODE_ADD_SYM: state_nxt = in_edge_ok ? ST_EDGE_RD : ST_DONE;
            MODE_BEGIN:   state_nxt = ST_CLOSE;
            MODE_CONSUME: state_nxt = ST_SCAN;
            MODE_CLEAR:   state_nxt = ST_CLEAR;
            default:      state_nxt = ST_DONE;
          endcase
        end
      end
      ST_EDGE_RD: state_nxt = ST_EDGE_WR;
      ST_EDGE_WR: state_nxt = ST_DONE;
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (close_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = clr_reply_r ? ST_DONE : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    item_nxt      = item_r;
    set_nxt       = set_r;
    active_nxt    = active_r;
    accept_nxt    = accept_r;
    eps_nxt       = eps_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = 1'b0;
    rd_sel_nxt    = 1'b0;
    clr_nxt       = clr_r;
    clr_reply_nxt = clr_reply_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = '0;
    ram_raddr     = edge_addr;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          unique case (in_data.mode)
            MODE_ADD_EPS: begin
              if (in_edge_ok) begin
                eps_nxt[in_data.from_state[STATE_W-1:0]] =
                  eps_r[in_data.from_state[STATE_W-1:0]] |
                  (mask_t'(1) << in_data.to_state[STATE_W-1:0]);
              end
            end
            MODE_SET_STOP: begin
              if (from_ok) begin
                accept_nxt[in_data.from_state[STATE_W-1:0]] = in_data.stop_flag;
              end
            end
            MODE_BEGIN: begin
              set_nxt = (int'(start_r) < NUM_STATES) ?
                        (mask_t'(1) << start_r[STATE_W-1:0]) : '0;
            end
            MODE_CONSUME: begin
              set_nxt = '0;
              idx_nxt = '0;
            end
            MODE_CLEAR: begin
              for (int i = 0; i < NUM_STATES; i++) begin
                eps_nxt[i] = '0;
              end
              accept_nxt    = '0;
              active_nxt    = '0;
              clr_nxt       = '0;
              clr_reply_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_EDGE_RD: ram_raddr = edge_addr;
      ST_EDGE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = edge_addr;
        ram_wdata = ram_rdata | (mask_t'(1) << item_r.to_state[STATE_W-1:0]);
      end
      ST_SCAN: begin
        // issue row read for idx_r, fold in the row read last cycle
        ram_raddr = {idx_r[STATE_W-1:0], item_r.symbol[SYMBOL_BITS-1:0]};
        set_nxt   = scan_acc;
        if (!scan_end) begin
          idx_nxt    = idx_r + IDX_W'(1);
          rd_vld_nxt = 1'b1;
          rd_sel_nxt = active_r[idx_r[STATE_W-1:0]];
        end
      end
      ST_CLOSE: begin
        if (close_done) begin
          active_nxt = set_r;
        end else begin
          set_nxt = grown;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.active_set = active_r[OUT_SET_W-1:0];
          out_data_nxt.accepting  = |(active_r & accept_r);
          out_data_nxt.dead       = (active_r == '0);
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
        if (clr_last) begin
          clr_reply_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      active_r    <= '0;
      accept_r    <= '0;
      for (int i = 0; i < NUM_STATES; i++) begin
        eps_r[i] <= '0;
      end
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      rd_sel_r    <= 1'b0;
      clr_r       <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      accept_r    <= accept_nxt;
      eps_r       <= eps_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_sel_r    <= rd_sel_nxt;
      clr_r       <= clr_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        start_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    set_r      <= set_nxt;
    out_data_r <= out_data_nxt;
  end

  // A result transaction only appears when the sequencer finishes an item
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside DONE");

  // The closure set only grows between passes
  a_close_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLOSE) && $past(state_r == ST_CLOSE) |->
      ((set_r & $past(set_r)) == $past(set_r)))
    else $error("closure set lost a state");

  // The sequencer stays idle until a transaction is accepted
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && !in_valid |=> (state_r == ST_IDLE))
    else $error("left IDLE without an input transaction");

  // Scan index never runs past one beyond the last state row
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= IDX_W'(NUM_STATES)))
    else $error("scan index out of range");

endmodule

FILE: test/nfa_match_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_match_checker
// Watches the input, result and start-state channels of the NFA matcher,
// keeps its own copy of the automaton and active set, and compares every
// returned transaction field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module nfa_match_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  nfaec_pkg::nfaec_in_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  nfaec_pkg::nfaec_out_t out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [3:0]            cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen
);
  import nfaec_pkg::*;

  localparam int NSYM = 1 << SYMBOL_BITS;

  mask_t      sym_next [NUM_STATES][NSYM];
  mask_t      eps_row [NUM_STATES];
  mask_t      accept_set;
  mask_t      live_set;
  logic [3:0] start_sel;
  nfaec_out_t nfa_replies [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch at %0t: %s: expected %0h, got %0h", $realtime, what, want, got);
    fail_count++;
  endtask

  // Grow the set along epsilon edges until it stops changing.
  function automatic mask_t eps_closure(input mask_t seed);
    mask_t cur;
    mask_t grown;
    int    p;
    int    s;
    cur = seed;
    for (p = 0; p < NUM_STATES; p++) begin
      grown = cur;
      for (s = 0; s < NUM_STATES; s++)
        if (cur[s]) grown |= eps_row[s];
      if (grown == cur) break;
      cur = grown;
    end
    return cur;
  endfunction

  task automatic clear_stores();
    int s;
    int c;
    for (s = 0; s < NUM_STATES; s++) begin
      eps_row[s] = '0;
      for (c = 0; c < NSYM; c++) sym_next[s][c] = '0;
    end
    accept_set = '0;
    live_set   = '0;
  endtask

  task automatic step_nfa(input nfaec_in_t it);
    mask_t      succ;
    nfaec_out_t r;
    int         s;
    case (it.mode)
      MODE_ADD_SYM:  sym_next[it.from_state][it.symbol][it.to_state] = 1'b1;
      MODE_ADD_EPS:  eps_row[it.from_state][it.to_state] = 1'b1;
      MODE_SET_STOP: accept_set[it.from_state] = it.stop_flag;
      MODE_BEGIN:    live_set = eps_closure(mask_t'(1) << start_sel);
      MODE_CONSUME: begin
        succ = '0;
        for (s = 0; s < NUM_STATES; s++)
          if (live_set[s]) succ |= sym_next[s][it.symbol];
        live_set = eps_closure(succ);
      end
      MODE_CLEAR:    clear_stores();
      default: ;
    endcase
    r.active_set = live_set[15:0];
    r.accepting  = |(live_set & accept_set);
    r.dead       = (live_set == '0);
    nfa_replies = {nfa_replies, r};
  endtask

  always @(posedge clk) begin
    nfaec_out_t want;
    if (!rst_n) begin
      clear_stores();
      start_sel = '0;
      nfa_replies.delete();
    end else begin
      // the block samples the old start state for an item taken at this edge
      if (in_valid && in_ready) step_nfa(in_data);
      if (cfg_valid && cfg_ready) start_sel = cfg_data;
      if (out_valid && out_ready) begin
        results_seen++;
        if (nfa_replies.size() == 0) begin
          report_mismatch("result with nothing pending", 0, out_data.active_set);
        end else begin
          want = nfa_replies.pop_front();
          if (out_data.active_set !== want.active_set)
            report_mismatch("active_set", want.active_set, out_data.active_set);
          if (out_data.accepting !== want.accepting)
            report_mismatch("accepting", want.accepting, out_data.accepting);
          if (out_data.dead !== want.dead)
            report_mismatch("dead", want.dead, out_data.dead);
        end
      end
    end
    pending = nfa_replies.size();
  end

endmodule

FILE: test/tb_nfa_epsilon_closure_matcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nfa_epsilon_closure_matcher_core
// Builds small automata in the matcher, begins matches and steps symbols
// through them under random input gaps and output stalls; a side checker
// predicts every result and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module tb_nfa_epsilon_closure_matcher_core;
  import nfaec_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 50;
  localparam int MAX_RAND_CLEARS = 10;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 60;

  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  nfaec_in_t  in_data;
  logic       out_valid;
  logic       out_ready;
  nfaec_out_t out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  int fail_count;
  int pending;
  int results_seen;
  int cycles = 0;
  int items_sent = 0;
  int cfg_writes = 0;
  int clears_sent = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  logic [7:0] alphabet [4];
  logic [3:0] hot_states [6];

  nfa_epsilon_closure_matcher_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  nfa_match_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= calm || ($urandom_range(99) >= 35);
    end
  end

  function automatic nfaec_in_t mk(input logic [2:0] m, input logic [3:0] f,
                                   input logic [3:0] t, input logic [7:0] s,
                                   input logic sf);
    nfaec_in_t it;
    it.mode       = m;
    it.from_state = f;
    it.to_state   = t;
    it.symbol     = s;
    it.stop_flag  = sf;
    return it;
  endfunction

  // Mostly edits and steps around a few hot states and symbols; some noise.
  function automatic nfaec_in_t rand_item();
    nfaec_in_t it;
    int        r;
    it = mk(3'($urandom_range(7)), 4'($urandom_range(15)), 4'($urandom_range(15)),
            8'($urandom_range(255)), 1'($urandom_range(1)));
    r = $urandom_range(99);
    if (r >= 20) begin
      it.from_state = hot_states[$urandom_range(5)];
      it.symbol     = alphabet[$urandom_range(3)];
      if ($urandom_range(99) < 70) it.to_state = hot_states[$urandom_range(5)];
      r = $urandom_range(99);
      if (r < 18)      it.mode = MODE_ADD_SYM;
      else if (r < 26) it.mode = MODE_ADD_EPS;
      else if (r < 36) it.mode = MODE_SET_STOP;
      else if (r < 46) it.mode = MODE_BEGIN;
      else if (r < 95) it.mode = MODE_CONSUME;
      else             it.mode = r[0] ? MODE_SPARE_A : MODE_SPARE_B;
    end
    // Clear-all sweeps the whole edge RAM; keep them few.
    if (it.mode == MODE_CLEAR && clears_sent >= MAX_RAND_CLEARS) it.mode = MODE_CONSUME;
    return it;
  endfunction

  task automatic send(input nfaec_in_t it);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
    if (it.mode == MODE_CLEAR) clears_sent++;
  endtask

  // Hold the input until every pending result is back and the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_start(input logic [3:0] st);
    cfg_valid <= 1'b1;
    cfg_data  <= st;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int         ph;
    int         k;
    logic [3:0] st;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_start(4'd0);
    // Empty automaton, then a dead set that must stay dead.
    send(mk(MODE_BEGIN, 4'd0, 4'd0, 8'h00, 1'b0));
    send(mk(MODE_CONSUME, 4'd0, 4'd0, 8'h00, 1'b0));
    send(mk(MODE_CONSUME, 4'd15, 4'd15, 8'hFF, 1'b1));
    // 0 -00-> 1 -FF-> 15, epsilon chain 15 -> 14 -> 0 and a self loop.
    send(mk(MODE_ADD_SYM, 4'd0, 4'd1, 8'h00, 1'b0));
    send(mk(MODE_ADD_SYM, 4'd1, 4'd15, 8'hFF, 1'b1));
    send(mk(MODE_ADD_EPS, 4'd15, 4'd14, 8'h00, 1'b0));
    send(mk(MODE_ADD_EPS, 4'd14, 4'd0, 8'hFF, 1'b0));
    send(mk(MODE_ADD_EPS, 4'd0, 4'd0, 8'h00, 1'b1));
    send(mk(MODE_SET_STOP, 4'd15, 4'd0, 8'h00, 1'b1));
    send(mk(MODE_SET_STOP, 4'd14, 4'd15, 8'hFF, 1'b1));
    send(mk(MODE_SET_STOP, 4'd14, 4'd0, 8'h00, 1'b0));
    send(mk(MODE_BEGIN, 4'd15, 4'd15, 8'hFF, 1'b1));
    send(mk(MODE_CONSUME, 4'd0, 4'd0, 8'h00, 1'b0));
    send(mk(MODE_CONSUME, 4'd0, 4'd0, 8'hFF, 1'b0));
    send(mk(MODE_SPARE_A, 4'd15, 4'd15, 8'hFF, 1'b1));
    send(mk(MODE_SPARE_B, 4'd0, 4'd0, 8'h00, 1'b0));
    send(mk(MODE_CONSUME, 4'd0, 4'd0, 8'h00, 1'b0));
    send(mk(MODE_CONSUME, 4'd0, 4'd0, 8'h00, 1'b0));
    send(mk(MODE_CLEAR, 4'd15, 4'd15, 8'hFF, 1'b1));
    send(mk(MODE_BEGIN, 4'd0, 4'd0, 8'h00, 1'b0));
    settle();
    write_start(4'd15);
    send(mk(MODE_BEGIN, 4'd0, 4'd0, 8'h00, 1'b0));
    send(mk(MODE_CONSUME, 4'd15, 4'd15, 8'hFF, 1'b0));

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == 3)               st = 4'd15;
      else if (ph == PHASES - 1) st = 4'd0;
      else                       st = 4'($urandom_range(15));
      write_start(st);
      hot_states[0] = st;
      for (k = 1; k < 6; k++) hot_states[k] = 4'($urandom_range(15));
      alphabet[0] = ph[0] ? 8'hFF : 8'h00;
      for (k = 1; k < 4; k++) alphabet[k] = 8'($urandom_range(255));
      calm = (ph == 2);
      if (ph == 5) hold_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) send(rand_item());
    end

    settle();
    $display("summary: %0d transactions (%0d clear-all), %0d start-state writes, %0d results",
             items_sent, clears_sent, cfg_writes, results_seen);
    $display("summary: one %0d-cycle output hold-off, one phase with no idling on either side",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: nfa_epsilon_closure_matcher_core.f
rtl/nfaec_pkg.sv
rtl/nfaec_ram.sv
rtl/nfa_epsilon_closure_matcher_core.sv
test/nfa_match_checker.sv
test/tb_nfa_epsilon_closure_matcher_core.sv
